### src/pkvt_pkg.sv
// Shared types and constants of the partitioned key/value table.
// No dependencies; imported by the top level and the checker.
package pkvt_pkg;

  localparam int unsigned TYP_W   = 1;
  localparam int unsigned OBJ_W   = 4;
  localparam int unsigned SYM_W   = 16;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned ENT_W   = SYM_W + VAL_W;
  localparam int unsigned S_DATA_W = 56;
  localparam int unsigned M_DATA_W = 32;

  localparam logic [VAL_W-1:0] VAL_MISS = '1;

  typedef enum logic {
    CMD_GET = 1'b0,
    CMD_SET = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_FWAIT,
    ST_SEARCH,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic full_error;
    logic found;
  } res_flags_t;

endpackage

### src/pkvt_ram.sv
// Single-port-write, single-port-read RAM with a registered read.
// Depends on nothing; used for the entry store and the fill counts.
module pkvt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/partitioned_key_value_table_top.sv
// Top level of the partitioned key/value table: sequencer, search loop and result register.
// Depends on pkvt_pkg and pkvt_ram.
//
// Channel   Direction  Handshake                      Payload
// s_axis    in         s_axis_tvalid / s_axis_tready  tdata: type, object, symbol, value
//                                                     tuser: command
// m_axis    out        m_axis_tvalid / m_axis_tready  tdata: read value
//                                                     tuser: found, full error
//
// A hit ends the search at the matching entry and a miss ends it once all n stored entries
// are compared, where n is the fill count of the partition (at most ENTRIES); an empty
// partition compares no entry and a type or object beyond the table skips the lookup. The
// entry store has one read port, so the search compares one stored entry per cycle against
// the requested symbol, and the next transaction can be taken in the cycle after the
// result is stored. After reset the fill counts are swept to zero, one partition per cycle;
// no transaction is accepted during that sweep.
// The block works on one item at a time. A finished result waits in the output register,
// and the next item may be accepted while it waits; that item holds in its last step until
// the register is free. The item's writes are done when its result enters the register.
module partitioned_key_value_table_top
  import pkvt_pkg::*;
#(
  parameter int unsigned TYPES   = 2,
  parameter int unsigned OBJECTS = 16,
  parameter int unsigned ENTRIES = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [0] type_id, [4:1] object_id, [20:5] symbol_id, [52:21] value, [55:53] zero
  input  logic [S_DATA_W-1:0] s_axis_tdata,
  // [0] command
  input  logic [0:0]          s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [31:0] read_value
  output logic [M_DATA_W-1:0] m_axis_tdata,
  // [0] found, [1] full_error
  output logic [1:0]          m_axis_tuser
);

  localparam int unsigned PARTS  = TYPES * OBJECTS;
  localparam int unsigned DEPTH  = PARTS * ENTRIES;
  localparam int unsigned PART_W = (PARTS > 1) ? $clog2(PARTS) : 1;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned IDX_W  = $clog2(ENTRIES);
  localparam int unsigned CNT_W  = $clog2(ENTRIES + 1);

  // Input fields.
  logic [TYP_W-1:0] in_type;
  logic [OBJ_W-1:0] in_obj;
  logic [SYM_W-1:0] in_sym;
  logic [VAL_W-1:0] in_val;
  logic [31:0]      part_wide;
  logic             in_range;

  assign in_type = s_axis_tdata[0];
  assign in_obj  = s_axis_tdata[4:1];
  assign in_sym  = s_axis_tdata[20:5];
  assign in_val  = s_axis_tdata[52:21];

  // The partition is type * OBJECTS + object; a type or object beyond the table skips the lookup.
  assign part_wide = 32'(in_type) * 32'(OBJECTS) + 32'(in_obj);
  assign in_range  = (32'(in_type) < 32'(TYPES)) && (32'(in_obj) < 32'(OBJECTS));

  state_e state_q, state_d;

  // Item registers.
  cmd_e              cmd_q, cmd_d;
  logic              oor_q, oor_d;
  logic [PART_W-1:0] part_q, part_d;
  logic [ADDR_W-1:0] base_q, base_d;
  logic [SYM_W-1:0]  sym_q, sym_d;
  logic [VAL_W-1:0]  val_q, val_d;
  logic [CNT_W-1:0]  n_q, n_d;

  // Search loop registers.
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic              cmp_vld_q, cmp_vld_d;
  logic [IDX_W-1:0]  cmp_idx_q, cmp_idx_d;
  logic              hit_q, hit_d;
  logic [IDX_W-1:0]  pos_q, pos_d;
  logic [VAL_W-1:0]  rval_q, rval_d;

  // Fill count sweep after reset.
  logic [PART_W-1:0] clr_q, clr_d;

  // Output register.
  logic              m_valid_q, m_valid_d;
  logic [VAL_W-1:0]  m_data_q, m_data_d;
  res_flags_t        m_flags_q, m_flags_d;

  // Memory ports.
  logic              ent_we, ent_re;
  logic [ADDR_W-1:0] ent_waddr, ent_raddr;
  logic [ENT_W-1:0]  ent_wdata, ent_rdata;
  logic              fill_we, fill_re;
  logic [PART_W-1:0] fill_waddr;
  logic [CNT_W-1:0]  fill_wdata, fill_rdata;

  logic [31:0]       base_wide;
  logic              s_accept;
  logic              out_free;
  logic              hit_now;
  logic              issue_ok;
  logic              part_full;

  assign base_wide = 32'(part_q) * 32'(ENTRIES);
  assign s_accept  = s_axis_tvalid && s_axis_tready;
  assign out_free  = !m_valid_q || m_axis_tready;
  assign hit_now   = cmp_vld_q && (ent_rdata[SYM_W-1:0] == sym_q);
  assign issue_ok  = idx_q < n_q;
  assign part_full = (n_q == CNT_W'(ENTRIES));

  pkvt_ram #(
    .WIDTH (ENT_W),
    .DEPTH (DEPTH)
  ) u_entries (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (ent_wdata),
    .re_i    (ent_re),
    .raddr_i (ent_raddr),
    .rdata_o (ent_rdata)
  );

  pkvt_ram #(
    .WIDTH (CNT_W),
    .DEPTH (PARTS)
  ) u_fill (
    .clk_i   (clk_i),
    .we_i    (fill_we),
    .waddr_i (fill_waddr),
    .wdata_i (fill_wdata),
    .re_i    (fill_re),
    .raddr_i (part_q),
    .rdata_o (fill_rdata)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == PART_W'(PARTS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_accept) begin
          state_d = in_range ? ST_LOOKUP : ST_FINISH;
        end
      end
      ST_LOOKUP: state_d = ST_FWAIT;
      ST_FWAIT:  state_d = ST_SEARCH;
      ST_SEARCH: begin
        // Stop on the first match, or once every entry has been compared.
        if (hit_now || (!issue_ok && !cmp_vld_q)) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // Datapath, memory controls and handshake outputs.
  always_comb begin
    cmd_d      = cmd_q;
    oor_d      = oor_q;
    part_d     = part_q;
    base_d     = base_q;
    sym_d      = sym_q;
    val_d      = val_q;
    n_d        = n_q;
    idx_d      = idx_q;
    cmp_vld_d  = cmp_vld_q;
    cmp_idx_d  = cmp_idx_q;
    hit_d      = hit_q;
    pos_d      = pos_q;
    rval_d     = rval_q;
    clr_d      = clr_q;
    m_valid_d  = m_valid_q && !m_axis_tready;
    m_data_d   = m_data_q;
    m_flags_d  = m_flags_q;
    ent_we     = 1'b0;
    ent_waddr  = base_q + ADDR_W'(pos_q);
    ent_wdata  = {val_q, sym_q};
    ent_re     = 1'b0;
    ent_raddr  = base_q + ADDR_W'(idx_q[IDX_W-1:0]);
    fill_we    = 1'b0;
    fill_waddr = part_q;
    fill_wdata = n_q + CNT_W'(1);
    fill_re    = 1'b0;
    s_axis_tready = 1'b0;

    case (state_q)
      ST_CLEAR: begin
        fill_we    = 1'b1;
        fill_waddr = clr_q;
        fill_wdata = '0;
        clr_d      = clr_q + PART_W'(1);
      end
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        cmd_d  = cmd_e'(s_axis_tuser[0]);
        oor_d  = !in_range;
        part_d = part_wide[PART_W-1:0];
        sym_d  = in_sym;
        val_d  = in_val;
        hit_d  = 1'b0;
      end
      ST_LOOKUP: begin
        fill_re = 1'b1;
        base_d  = base_wide[ADDR_W-1:0];
      end
      ST_FWAIT: begin
        n_d       = fill_rdata;
        idx_d     = '0;
        cmp_vld_d = 1'b0;
      end
      ST_SEARCH: begin
        if (hit_now) begin
          hit_d     = 1'b1;
          pos_d     = cmp_idx_q;
          rval_d    = ent_rdata[ENT_W-1:SYM_W];
          cmp_vld_d = 1'b0;
        end else if (issue_ok) begin
          // Read the next entry; it is compared in the following cycle.
          ent_re    = 1'b1;
          idx_d     = idx_q + CNT_W'(1);
          cmp_vld_d = 1'b1;
          cmp_idx_d = idx_q[IDX_W-1:0];
        end else begin
          cmp_vld_d = 1'b0;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          if (cmd_q == CMD_GET) begin
            m_data_d             = hit_q ? rval_q : VAL_MISS;
            m_flags_d.found      = hit_q;
            m_flags_d.full_error = 1'b0;
          end else begin
            m_data_d             = '0;
            m_flags_d.found      = hit_q;
            m_flags_d.full_error = !hit_q && (oor_q || part_full);
            if (hit_q) begin
              // Overwrite the value of the matching entry.
              ent_we = 1'b1;
            end else if (!oor_q && !part_full) begin
              // Append a new entry and bump the partition's fill count.
              ent_we    = 1'b1;
              ent_waddr = base_q + ADDR_W'(n_q[IDX_W-1:0]);
              fill_we   = 1'b1;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      cmp_vld_q <= 1'b0;
      hit_q     <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      cmp_vld_q <= cmp_vld_d;
      hit_q     <= hit_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    oor_q     <= oor_d;
    part_q    <= part_d;
    base_q    <= base_d;
    sym_q     <= sym_d;
    val_q     <= val_d;
    n_q       <= n_d;
    idx_q     <= idx_d;
    cmp_idx_q <= cmp_idx_d;
    pos_q     <= pos_d;
    rval_q    <= rval_d;
    m_data_q  <= m_data_d;
    m_flags_q <= m_flags_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = {m_flags_q.full_error, m_flags_q.found};

endmodule

### src/pkvt_checker.sv
// Port-level checks of the partitioned key/value table, bound to its top level.
// Depends on pkvt_pkg and partitioned_key_value_table_top.
module pkvt_checker
  import pkvt_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic [S_DATA_W-1:0] s_axis_tdata,
  input logic [0:0]          s_axis_tuser,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [M_DATA_W-1:0] m_axis_tdata,
  input logic [1:0]          m_axis_tuser
);

  // A result that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result withdrawn while stalled");

  // Only one item is in work at a time.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while an item is in work");

  // A hit can never also report a full partition.
  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("found and full_error both set");

  // A nonzero value without a hit can only be the miss answer of a get.
  a_miss_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] && (m_axis_tdata != 32'd0)
      |-> (m_axis_tdata == 32'hFFFF_FFFF) && !m_axis_tuser[1])
    else $error("bad value on a miss");

endmodule

bind partitioned_key_value_table_top pkvt_checker u_pkvt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
